[src/utu_pkg.sv]
// ----------------------------------------------------------------------------
// utu_pkg: shared definitions for the UTF-16 to UTF-8 transcoder
// Holds the code-unit constants, the queue depth and the encoded entry that
// the front end hands to the byte serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

package utu_pkg;

  // Code-unit and code-point widths.
  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;
  localparam int BYTE_W = 8;
  localparam int MAX_BYTES = 4;
  localparam int IDX_W  = $clog2(MAX_BYTES);

  // High-surrogate range and the combining offset.
  localparam logic [UNIT_W-1:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [UNIT_W-1:0] HI_SURR_LAST  = 16'hDBFF;
  // 0x10000 - 0xDC00, folded into a single constant.
  localparam logic [CP_W-1:0]   PAIR_OFFSET   = 21'h002400;

  // Encoding thresholds.
  localparam logic [CP_W-1:0] LIMIT_1B = 21'h00007F;
  localparam logic [CP_W-1:0] LIMIT_2B = 21'h0007FF;
  localparam logic [CP_W-1:0] LIMIT_3B = 21'h00FFFF;

  // Lead and continuation byte marks.
  localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MK = 8'h80;

  // Queue between front end and serialiser.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One encoded code point: bytes in emission order, index of the final byte
  // and the end-of-text mark of the item that completed it.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
    logic                             eot;
  } utu_entry_t;

endpackage : utu_pkg

`default_nettype wire

[src/utu_front.sv]
// ----------------------------------------------------------------------------
// utu_front: code-unit intake and encoder
// Accepts code units, pairs surrogates and encodes each completed code point
// into one queue entry of up to four UTF-8 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [utu_pkg::UNIT_W-1:0]   in_tdata,   // [15:0] code_unit
  input  wire                          in_tlast,   // end_of_text
  output logic                         push_valid,
  input  wire                          push_ready,
  output utu_pkg::utu_entry_t          push_entry
);

  import utu_pkg::*;

  logic             pend_r, pend_nxt;
  logic [9:0]       held_r, held_nxt;
  logic             accept;
  logic             is_hi;
  logic             hold;
  logic [CP_W-1:0]  cp;

  // Input is taken whenever the queue has room.
  assign in_tready = push_ready;
  assign accept    = in_tvalid && in_tready;

  // Classify the unit: a high surrogate that is not final is held back.
  always_comb begin
    is_hi = in_tdata inside {[HI_SURR_FIRST:HI_SURR_LAST]};
    hold  = !pend_r && is_hi && !in_tlast;
  end

  // Form the code point; a unit following a held half is combined unchecked.
  always_comb begin
    if (pend_r) begin
      cp = {1'b0, held_r, 10'b0} + {{(CP_W-UNIT_W){1'b0}}, in_tdata} + PAIR_OFFSET;
    end else begin
      cp = {{(CP_W-UNIT_W){1'b0}}, in_tdata};
    end
  end

  // Encode into lead and continuation bytes.
  always_comb begin
    push_entry          = '0;
    push_entry.eot      = in_tlast;
    if (cp <= LIMIT_1B) begin
      push_entry.bytes[0] = cp[7:0];
      push_entry.last_idx = IDX_W'(0);
    end else if (cp <= LIMIT_2B) begin
      push_entry.bytes[0] = LEAD_2B | {3'b0, cp[10:6]};
      push_entry.bytes[1] = CONT_MK | {2'b0, cp[5:0]};
      push_entry.last_idx = IDX_W'(1);
    end else if (cp <= LIMIT_3B) begin
      push_entry.bytes[0] = LEAD_3B | {4'b0, cp[15:12]};
      push_entry.bytes[1] = CONT_MK | {2'b0, cp[11:6]};
      push_entry.bytes[2] = CONT_MK | {2'b0, cp[5:0]};
      push_entry.last_idx = IDX_W'(2);
    end else begin
      push_entry.bytes[0] = LEAD_4B | {5'b0, cp[20:18]};
      push_entry.bytes[1] = CONT_MK | {2'b0, cp[17:12]};
      push_entry.bytes[2] = CONT_MK | {2'b0, cp[11:6]};
      push_entry.bytes[3] = CONT_MK | {2'b0, cp[5:0]};
      push_entry.last_idx = IDX_W'(3);
    end
  end

  assign push_valid = accept && !hold;

  // Surrogate state update on every accepted transfer.
  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    if (accept) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
        held_nxt = '0;
      end else if (hold) begin
        pend_nxt = 1'b1;
        held_nxt = in_tdata[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule : utu_front

`default_nettype wire

[src/utu_queue.sv]
// ----------------------------------------------------------------------------
// utu_queue: short entry queue
// A small first-in first-out store that decouples the encoder from the byte
// serialiser so that each side may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr_valid,
  output logic                 wr_ready,
  input  utu_pkg::utu_entry_t  wr_entry,
  output logic                 rd_valid,
  input  wire                  rd_ready,
  output utu_pkg::utu_entry_t  rd_entry
);

  import utu_pkg::*;

  utu_entry_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign wr_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and fill-count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

endmodule : utu_queue

`default_nettype wire

[src/utu_back.sv]
// ----------------------------------------------------------------------------
// utu_back: byte serialiser
// Takes one encoded entry at a time and sends its bytes one per cycle unless
// stalled, through a registered output, marking the final byte of each run.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          pop_valid,
  output logic                         pop_ready,
  input  utu_pkg::utu_entry_t          pop_entry,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [utu_pkg::BYTE_W-1:0]   out_tdata,  // [7:0] utf8_byte
  output logic                         out_tlast,  // last_of_run
  output logic                         out_tuser   // text_done
);

  import utu_pkg::*;

  utu_entry_t         cur_r, cur_nxt;
  logic               cur_vld_r, cur_vld_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ovld_r, ovld_nxt;
  logic [BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic               olast_r, olast_nxt;
  logic               odone_r, odone_nxt;
  logic               load_out;
  logic               at_end;

  // A byte moves into the output register when it is empty or being drained.
  assign at_end    = (idx_r == cur_r.last_idx);
  assign load_out  = cur_vld_r && (!ovld_r || out_tready);
  assign pop_ready = !cur_vld_r || (load_out && at_end);

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    ovld_nxt    = ovld_r;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    odone_nxt   = odone_r;

    // Output register drains on a completed transfer.
    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    // Next byte of the current entry.
    if (load_out) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = cur_r.bytes[idx_r];
      olast_nxt = at_end;
      odone_nxt = at_end && cur_r.eot;
      idx_nxt   = idx_r + 1'b1;
      if (at_end) begin
        cur_vld_nxt = 1'b0;
      end
    end

    // Fetch a fresh entry once the current one has been used up.
    if (pop_valid && pop_ready) begin
      cur_nxt     = pop_entry;
      cur_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      ovld_r    <= 1'b0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      ovld_r    <= ovld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = odone_r;

endmodule : utu_back

`default_nettype wire

[src/utf16_to_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder: UTF-16 code units in, UTF-8 bytes out
// Top level joining the encoder front end, the entry queue and the byte
// serialiser.
// ----------------------------------------------------------------------------
// One code unit is taken per transfer on the input stream, with tlast marking
// the final unit of a string. Each completed code point leaves as one to four
// bytes, one byte per cycle while the output is not stalled, from a registered
// output; tlast marks the final byte of each run and tuser the final byte of
// the string. A high surrogate that is not final is held and produces no
// bytes; the next unit is combined with it unchecked. The sustained rate is
// set by the output serialiser, which takes the next entry as the last byte of
// the current one is loaded. A two-entry queue lets the input keep accepting
// while the output is stalled. No clearing pass is needed after reset.
`default_nettype none

module utf16_to_utf8_transcoder (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [utu_pkg::UNIT_W-1:0]   in_tdata,   // [15:0] code_unit
  input  wire                          in_tlast,   // end_of_text
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [utu_pkg::BYTE_W-1:0]   out_tdata,  // [7:0] utf8_byte
  output logic                         out_tlast,  // last_of_run
  output logic                         out_tuser   // text_done
);

  import utu_pkg::*;

  logic        push_valid, push_ready;
  utu_entry_t  push_entry;
  logic        pop_valid, pop_ready;
  utu_entry_t  pop_entry;

  // Intake and encoding.
  utu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  utu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_entry (push_entry),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_entry (pop_entry)
  );

  // Byte serialiser.
  utu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule : utf16_to_utf8_transcoder

`default_nettype wire

[src/utu_checker.sv]
// ----------------------------------------------------------------------------
// utu_checker: port-level checks for the transcoder
// Watches the top-level streams and flags behaviour the encoder must never
// show; attached to the top level by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [7:0]  out_tdata,
  input wire        out_tlast,
  input wire        out_tuser
);

  // End of string is only ever flagged on the final byte of a run.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast || !out_tuser))
    else $error("text end flagged on a byte that does not close its run");

  // Any byte that is not the last of its run belongs to a multi-byte form.
  a_multi_hi_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> out_tdata[7])
    else $error("non-final byte without the high bit set");

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tlast) && $stable(out_tuser)))
    else $error("output byte changed while stalled");

  // Reset leaves nothing on the output and the queue empty.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready straight after reset");

endmodule : utu_checker

bind utf16_to_utf8_transcoder utu_checker u_utu_checker (.*);

`default_nettype wire

[verif/utf16_to_utf8_checker.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_checker: byte predictor and scoreboard for the transcoder
// Watches both stream channels and works out the UTF-8 bytes that each
// accepted code unit should produce. Every output transfer is then compared
// in order with the oldest predicted byte.
// ----------------------------------------------------------------------------
module utf16_to_utf8_checker (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  input  wire                        in_tready,
  input  wire  [utu_pkg::UNIT_W-1:0] in_tdata,
  input  wire                        in_tlast,
  input  wire                        out_tvalid,
  input  wire                        out_tready,
  input  wire  [utu_pkg::BYTE_W-1:0] out_tdata,
  input  wire                        out_tlast,
  input  wire                        out_tuser,
  output int unsigned                errors,
  output int unsigned                backlog,
  output int unsigned                bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import utu_pkg::*;

  // One predicted output byte with its run and string marks.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              run_end;
    logic              text_end;
  } utf8_byte_t;

  utf8_byte_t        utf8_expected[$];
  logic              high_held;
  logic [9:0]        high_bits;

  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic run_end,
                           input logic eot);
    utf8_byte_t b;
    b.value    = value;
    b.run_end  = run_end;
    b.text_end = run_end & eot;
    utf8_expected.insert(utf8_expected.size(), b);
  endtask

  // Predict the bytes of one accepted code unit and update the held surrogate.
  task automatic predict_unit(input logic [UNIT_W-1:0] unit, input logic eot);
    logic [CP_W-1:0] cp;
    logic            emit;
    emit = 1'b1;
    cp   = '0;
    if (high_held) begin
      // Whatever follows a held high surrogate is taken as its low half.
      cp        = 21'h010000 + {high_bits, 10'b0} + unit - 21'h00DC00;
      high_held = 1'b0;
      high_bits = '0;
    end else if (unit >= HI_SURR_FIRST && unit <= HI_SURR_LAST && !eot) begin
      high_held = 1'b1;
      high_bits = unit[9:0];
      emit      = 1'b0;
    end else begin
      cp = {5'd0, unit};
    end

    if (emit) begin
      if (cp <= LIMIT_1B) begin
        push_byte(cp[7:0], 1'b1, eot);
      end else if (cp <= LIMIT_2B) begin
        push_byte(LEAD_2B | {3'b0, cp[10:6]}, 1'b0, eot);
        push_byte(CONT_MK | {2'b0, cp[5:0]}, 1'b1, eot);
      end else if (cp <= LIMIT_3B) begin
        push_byte(LEAD_3B | {4'b0, cp[15:12]}, 1'b0, eot);
        push_byte(CONT_MK | {2'b0, cp[11:6]}, 1'b0, eot);
        push_byte(CONT_MK | {2'b0, cp[5:0]}, 1'b1, eot);
      end else begin
        // Values past the Unicode range keep only three bits in the lead byte.
        push_byte(LEAD_4B | {5'b0, cp[20:18]}, 1'b0, eot);
        push_byte(CONT_MK | {2'b0, cp[17:12]}, 1'b0, eot);
        push_byte(CONT_MK | {2'b0, cp[11:6]}, 1'b0, eot);
        push_byte(CONT_MK | {2'b0, cp[5:0]}, 1'b1, eot);
      end
    end
  endtask

  // Compare output transfers first, then predict from the input transfer.
  always @(posedge clk) begin : scoreboard
    utf8_byte_t want;
    if (!rst_n) begin
      high_held     = 1'b0;
      high_bits     = '0;
      errors        = 0;
      backlog       = 0;
      bytes_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        bytes_checked++;
        if (utf8_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected byte %02h last %b done %b", $realtime,
                     out_tdata, out_tlast, out_tuser);
        end else begin
          want = utf8_expected.pop_front();
          if (out_tdata !== want.value || out_tlast !== want.run_end ||
              out_tuser !== want.text_end) begin
            errors++;
            if (errors <= 10)
              $display("%0t: expected byte %02h last %b done %b, got %02h %b %b",
                       $realtime, want.value, want.run_end, want.text_end,
                       out_tdata, out_tlast, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_unit(in_tdata, in_tlast);
      backlog = utf8_expected.size();
    end
  end

endmodule

[verif/utf16_to_utf8_transcoder_test.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_test: stimulus and verdict for the transcoder
// Drives directed code units covering the encoding boundaries and surrogate
// corner cases, then a few hundred random units, mostly well-formed text with
// surrogate pairs and some noise, under random stalls on both streams.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utu_pkg::*;

  // Kinds of random code unit.
  typedef enum int {
    UNIT_ASCII,
    UNIT_TWO_BYTE,
    UNIT_BMP,
    UNIT_PAIR,
    UNIT_NOISE
  } unit_kind_t;

  localparam int unsigned TOTAL_UNITS = 475;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [UNIT_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tready = 1'b0;
  wire               in_tready;
  wire               out_tvalid;
  wire  [BYTE_W-1:0] out_tdata;
  wire               out_tlast;
  wire               out_tuser;

  int unsigned errors;
  int unsigned backlog;
  int unsigned bytes_checked;
  int unsigned units_sent      = 0;
  int unsigned pairs_sent      = 0;
  int unsigned strings_sent    = 0;
  int unsigned valid_gap_pct   = 20;
  int unsigned ready_stall_pct = 20;
  bit          calm            = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  utf16_to_utf8_transcoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  utf16_to_utf8_checker byte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .errors        (errors),
    .backlog       (backlog),
    .bytes_checked (bytes_checked)
  );

  // Watchdog for a hung run.
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Output back-pressure: random bursts of stalled cycles.
  initial begin : ready_driver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < ready_stall_pct)
          stall_left = $urandom_range(1, 15);
      end
    end
  end

  // One input transfer; valid stays high into the next call when no gap is due.
  task automatic send_unit(input logic [UNIT_W-1:0] unit, input logic eot);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= unit;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    units_sent++;
    if (eot)
      strings_sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < valid_gap_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk);
    end
  endtask

  // Hold the input off until every predicted byte has left the block.
  task automatic drain_pause();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  task automatic send_random_item();
    unit_kind_t        kind;
    int unsigned       pick;
    logic              eot;
    logic [UNIT_W-1:0] unit;
    pick = $urandom_range(0, 99);
    eot  = ($urandom_range(0, 7) == 0);
    if (pick < 30)      kind = UNIT_ASCII;
    else if (pick < 45) kind = UNIT_TWO_BYTE;
    else if (pick < 62) kind = UNIT_BMP;
    else if (pick < 90) kind = UNIT_PAIR;
    else                kind = UNIT_NOISE;

    case (kind)
      UNIT_ASCII:    unit = UNIT_W'($urandom_range(0, 'h7F));
      UNIT_TWO_BYTE: unit = UNIT_W'($urandom_range('h80, 'h7FF));
      UNIT_BMP:      unit = UNIT_W'($urandom_range('h800, 'hFFFF));
      UNIT_NOISE:    unit = UNIT_W'($urandom_range(0, 'hFFFF));
      default:       unit = UNIT_W'($urandom_range('hD800, 'hDBFF));
    endcase

    sender_gap();
    if (kind == UNIT_PAIR) begin
      send_unit(unit, 1'b0);
      sender_gap();
      send_unit(UNIT_W'($urandom_range('hDC00, 'hDFFF)), eot);
      pairs_sent++;
    end else begin
      send_unit(unit, eot);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Encoding boundaries.
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hE000, 1'b0);
    // Smallest and largest proper surrogate pairs.
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    // Unchecked low half: past the Unicode range, below 0x10000, and a
    // second high surrogate taken as the low half.
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hDA00, 1'b0);
    send_unit(16'hD800, 1'b0);
    // Lone low surrogates and a high surrogate that ends the string.
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    // End mark on the low half of a pair.
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b1);
    send_unit(16'h0041, 1'b1);
    send_unit(16'hAAAA, 1'b0);
    send_unit(16'h5555, 1'b1);
    drain_pause();

    // Random text in phases: moderate idling, none, heavy, then none to the end.
    while (units_sent < TOTAL_UNITS) begin
      if (units_sent >= TOTAL_UNITS - 75) begin
        calm = 1'b1;
      end else if (units_sent >= 220) begin
        valid_gap_pct   = 40;
        ready_stall_pct = 40;
      end else if (units_sent >= 150) begin
        valid_gap_pct   = 0;
        ready_stall_pct = 0;
      end
      if (units_sent >= 300 && units_sent < 302)
        drain_pause();
      send_random_item();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    for (int i = 0; i < 4000 && backlog != 0; i++) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d code units in %0d strings, %0d of them surrogate pairs.",
             units_sent, strings_sent, pairs_sent);
    $display("Checked %0d UTF-8 bytes; %0d wrong or unexpected, %0d never seen.",
             bytes_checked, errors, backlog);
    if (errors == 0 && backlog == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
